>>> sv/fat12_chain_checker_assert.svh
// Assertion macros shared by the chain checker RTL.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef FAT12_CHAIN_CHECKER_ASSERT_SVH
`define FAT12_CHAIN_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FCC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/fcc_pkg.sv
// Shared types and constants of the FAT12 chain checker.
// No dependencies; imported by the sequencer and the top level.
`default_nettype none

package fcc_pkg;

   localparam int CL_W = 12;
   localparam int ID_W = 16;

   localparam logic [CL_W-1:0] FAT_BAD       = 12'hFF7;
   localparam logic [CL_W-1:0] FAT_EOC       = 12'hFF8;
   localparam logic [CL_W-1:0] FAT_RSV_LO    = 12'hFF0;
   localparam logic [CL_W-1:0] FAT_RSV_HI    = 12'hFF6;
   localparam logic [CL_W-1:0] CNT_MAX       = 12'h0FFF;
   localparam logic [CL_W-1:0] FIRST_CLUSTER = 12'd2;
   localparam logic [CL_W-1:0] CC_RESET      = 12'd2847;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_CLEAR = 2'd1,
      OP_WALK  = 2'd2,
      OP_LOST  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_LOOP = 2'd1,
      ST_BAD  = 2'd2,
      ST_RSV  = 2'd3
   } st_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK_CHK,
      S_WALK_EVAL,
      S_SCAN,
      S_FIN
   } state_type;

   typedef struct packed {
      logic            we;
      logic [CL_W-1:0] waddr;
      logic [CL_W-1:0] wdata;
      logic [CL_W-1:0] raddr;
   } fat_port_type;

   typedef struct packed {
      logic            we;
      logic [CL_W-1:0] waddr;
      logic [ID_W-1:0] wdata;
      logic [CL_W-1:0] raddr;
   } own_port_type;

endpackage

`default_nettype wire

>>> sv/fcc_ram.sv
// Single-port-write, single-port-read synchronous RAM, registered read data.
// No dependencies; holds the FAT and owner tables.
`default_nettype none

module fcc_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> sv/fcc_seq.sv
// Sequencer of the chain checker: opcode decode, chain walk, lost scan,
// owner clearing pass and the result register. Uses fcc_pkg.
`default_nettype none

module fcc_seq #(
   parameter int TABLE_DEPTH = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [11:0]           cluster_count,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [39:0]           req_tdata,
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [55:0]                rsp_tdata,
   output fcc_pkg::fat_port_type      fat_port,
   input  wire logic [11:0]           fat_rdata,
   output fcc_pkg::own_port_type      own_port,
   input  wire logic [15:0]           own_rdata
);

   import fcc_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [CL_W:0] DEPTH_EXT = (CL_W+1)'(TABLE_DEPTH);
   localparam logic [AW-1:0] CLR_LAST  = AW'(TABLE_DEPTH - 1);

   state_type       state_ff, state_in;
   logic [CL_W-1:0] cl_ff, cl_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic [CL_W-1:0] len_ff, len_in;
   logic [CL_W-1:0] xcnt_ff, xcnt_in;
   logic [CL_W-1:0] xfirst_ff, xfirst_in;
   logic            seen_ff, seen_in;
   st_type          status_ff, status_in;
   logic [CL_W-1:0] stop_ff, stop_in;
   logic            fwd_ff, fwd_in;
   logic [CL_W:0]   n_ff, n_in;
   logic            pend_ff, pend_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic            clr_rsp_ff, clr_rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [55:0]     rsp_data_ff, rsp_data_in;

   logic [CL_W:0]   cc_plus2;
   logic [CL_W:0]   lim;
   logic            accept;
   op_type          op;
   logic [ID_W-1:0] own_cur;
   logic            is_loop;
   logic            is_xl;
   logic [CL_W-1:0] len_inc;
   logic            nx_rsv;
   logic            nx_end;
   logic            nx_ok;
   logic            chk_ok;
   logic            walk_go;
   logic            scan_issue;
   logic            fin_free;

   function automatic logic in_range(input logic [CL_W-1:0] c, input logic [CL_W-1:0] l,
                                     input logic [CL_W:0] lm, input logic [CL_W-1:0] cc);
      return (c >= FIRST_CLUSTER) && ({1'b0, c} < lm) && (l < cc);
   endfunction

   assign cc_plus2   = {1'b0, cluster_count} + (CL_W+1)'(2);
   assign lim        = (cc_plus2 < DEPTH_EXT) ? cc_plus2 : DEPTH_EXT;
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   // the owner write of the previous cluster lands in the same cycle as this read
   assign own_cur    = fwd_ff ? id_ff : own_rdata;
   assign is_loop    = (own_cur == id_ff);
   assign is_xl      = (own_cur != '0) && !is_loop;
   assign len_inc    = len_ff + CL_W'(1);
   assign nx_rsv     = fat_rdata inside {[FAT_RSV_LO:FAT_RSV_HI]};
   assign nx_end     = (fat_rdata >= FAT_EOC) || (fat_rdata == FAT_BAD) || nx_rsv;
   assign nx_ok      = in_range(fat_rdata, len_inc, lim, cluster_count);
   assign chk_ok     = in_range(cl_ff, len_ff, lim, cluster_count);
   assign walk_go    = !is_loop && !nx_end && nx_ok;
   assign scan_issue = (n_ff < lim);
   assign fin_free   = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == CLR_LAST) begin
               state_in = clr_rsp_ff ? S_FIN : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (op)
                  OP_WRITE: state_in = S_FIN;
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_WALK:  state_in = S_WALK_CHK;
                  OP_LOST:  state_in = S_SCAN;
                  default:  state_in = S_FIN;
               endcase
            end
         end
         S_WALK_CHK:  state_in = chk_ok ? S_WALK_EVAL : S_FIN;
         S_WALK_EVAL: state_in = walk_go ? S_WALK_EVAL : S_FIN;
         S_SCAN: begin
            if (!scan_issue && !pend_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (fin_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs: handshake and memory ports
   always_comb begin
      req_tready     = (state_ff == S_IDLE);
      fat_port       = '0;
      own_port       = '0;
      fat_port.raddr = cl_ff;
      own_port.raddr = cl_ff;
      case (state_ff)
         S_CLEAR: begin
            own_port.we    = 1'b1;
            own_port.waddr = CL_W'(clr_ff);
         end
         S_IDLE: begin
            if (accept && op == OP_WRITE && ({1'b0, req_tdata[11:0]} < DEPTH_EXT)) begin
               fat_port.we    = 1'b1;
               fat_port.waddr = req_tdata[11:0];
               fat_port.wdata = req_tdata[23:12];
            end
         end
         S_WALK_EVAL: begin
            if (!is_loop) begin
               own_port.we    = 1'b1;
               own_port.waddr = cl_ff;
               own_port.wdata = id_ff;
            end
            if (walk_go) begin
               fat_port.raddr = fat_rdata;
               own_port.raddr = fat_rdata;
            end
         end
         S_SCAN: begin
            fat_port.raddr = n_ff[CL_W-1:0];
            own_port.raddr = n_ff[CL_W-1:0];
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      cl_in        = cl_ff;
      id_in        = id_ff;
      len_in       = len_ff;
      xcnt_in      = xcnt_ff;
      xfirst_in    = xfirst_ff;
      seen_in      = seen_ff;
      status_in    = status_ff;
      stop_in      = stop_ff;
      fwd_in       = 1'b0;
      n_in         = n_ff;
      pend_in      = pend_ff;
      clr_in       = clr_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
         end
         S_IDLE: begin
            if (accept) begin
               cl_in      = req_tdata[11:0];
               id_in      = req_tdata[39:24];
               len_in     = '0;
               xcnt_in    = '0;
               xfirst_in  = '0;
               seen_in    = 1'b0;
               status_in  = ST_OK;
               stop_in    = '0;
               n_in       = (CL_W+1)'(FIRST_CLUSTER);
               pend_in    = 1'b0;
               clr_in     = '0;
               clr_rsp_in = 1'b1;
            end
         end
         S_WALK_CHK: begin
            if (!chk_ok) begin
               stop_in = cl_ff;
            end
         end
         S_WALK_EVAL: begin
            if (is_loop) begin
               status_in = ST_LOOP;
               stop_in   = cl_ff;
            end else begin
               len_in = len_inc;
               if (is_xl) begin
                  if (!seen_ff) begin
                     xfirst_in = cl_ff;
                     seen_in   = 1'b1;
                  end
                  if (xcnt_ff != CNT_MAX) begin
                     xcnt_in = xcnt_ff + CL_W'(1);
                  end
               end
               if (fat_rdata == FAT_BAD) begin
                  status_in = ST_BAD;
                  stop_in   = cl_ff;
               end else if (fat_rdata >= FAT_EOC) begin
                  stop_in = cl_ff;
               end else if (nx_rsv) begin
                  status_in = ST_RSV;
                  stop_in   = cl_ff;
               end else begin
                  cl_in = fat_rdata;
                  if (!nx_ok) begin
                     stop_in = fat_rdata;
                  end else begin
                     fwd_in = (fat_rdata == cl_ff);
                  end
               end
            end
         end
         S_SCAN: begin
            if (pend_ff && fat_rdata != '0 && fat_rdata != FAT_BAD && own_rdata == '0) begin
               len_in = len_inc;
            end
            pend_in = scan_issue;
            if (scan_issue) begin
               n_in = n_ff + (CL_W+1)'(1);
            end
         end
         S_FIN: begin
            if (fin_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, stop_ff, xfirst_ff, xcnt_ff, len_ff, status_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_ff       <= fwd_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cl_ff       <= cl_in;
      id_ff       <= id_in;
      len_ff      <= len_in;
      xcnt_ff     <= xcnt_in;
      xfirst_ff   <= xfirst_in;
      seen_ff     <= seen_in;
      status_ff   <= status_in;
      stop_ff     <= stop_in;
      n_ff        <= n_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> sv/fat12_chain_checker.sv
// FAT12 chain checker: a FAT table and an owner table in two synchronous RAMs,
// driven by one sequencer. One result beat per request beat. After reset the
// owner table has all TABLE_DEPTH entries cleared while req_tready is low.
// A walk does a read-modify-write on the owner RAM per cluster visited, with one
// read of both tables per cluster; a lost count does one read of both tables per
// scanned cluster. The result register lets the next request start while a
// result waits on rsp_tready.
// Depends on fcc_pkg, fcc_ram, fcc_seq and fat12_chain_checker_assert.svh.
`default_nettype none

module fat12_chain_checker #(
   parameter int TABLE_DEPTH = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [11:0] csr_data,   // cluster_count
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // cluster[11:0], entry_value[23:12], owner_id[39:24]
   input  wire logic [1:0]  req_tuser,  // opcode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata   // status[1:0], chain_length[13:2],
                                        // crosslink_count[25:14], first_crosslink[37:26],
                                        // stop_cluster[49:38], zero[55:50]
);

   import fcc_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [CL_W-1:0] cc_ff, cc_in;
   fat_port_type    fat_port;
   own_port_type    own_port;
   logic [CL_W-1:0] fat_rdata;
   logic [ID_W-1:0] own_rdata;

   assign csr_ready = 1'b1;
   assign cc_in     = (csr_valid && csr_ready) ? csr_data : cc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff <= CC_RESET;
      end else begin
         cc_ff <= cc_in;
      end
   end

   fcc_seq #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .cluster_count (cc_ff),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fat_port      (fat_port),
      .fat_rdata     (fat_rdata),
      .own_port      (own_port),
      .own_rdata     (own_rdata)
   );

   fcc_ram #(
      .WIDTH (CL_W),
      .DEPTH (TABLE_DEPTH)
   ) u_fat_ram (
      .clock (clock),
      .we    (fat_port.we),
      .waddr (fat_port.waddr[AW-1:0]),
      .wdata (fat_port.wdata),
      .raddr (fat_port.raddr[AW-1:0]),
      .rdata (fat_rdata)
   );

   fcc_ram #(
      .WIDTH (ID_W),
      .DEPTH (TABLE_DEPTH)
   ) u_own_ram (
      .clock (clock),
      .we    (own_port.we),
      .waddr (own_port.waddr[AW-1:0]),
      .wdata (own_port.wdata),
      .raddr (own_port.raddr[AW-1:0]),
      .rdata (own_rdata)
   );

`include "fat12_chain_checker_assert.svh"

   `FCC_ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready, "request taken while busy")
   `FCC_ASSERT_NOW(a_fat_we_on_write, fat_port.we, req_tvalid && req_tready && req_tuser == OP_WRITE, "FAT write outside a write beat")
   `FCC_ASSERT_NOW(a_own_waddr_range, own_port.we, {1'b0, own_port.waddr} < (CL_W+1)'(TABLE_DEPTH), "owner write beyond table")
   `FCC_ASSERT_NOW(a_no_dual_write, fat_port.we, !own_port.we, "FAT and owner written together")

endmodule

`default_nettype wire
